// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, quiet during reset
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("fail");
// next-cycle implication checked every clock, quiet during reset
`define ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("fail");
`endif

// File: rtl/sgdm_pkg.sv
// ----------------------------------------------------------------------------
// sgdm_pkg
// types, constants and arithmetic helpers of the momentum gradient engine
// ----------------------------------------------------------------------------
`default_nettype none
package sgdm_pkg;
  localparam int MAX_INPUTS_DEF  = 16;
  localparam int MAX_OUTPUTS_DEF = 16;
  localparam int VBITS = 24;
  localparam int FBITS = 16;
  localparam int QDEPTH = 2;

  localparam logic [2:0] REQ_ACT   = 3'd0;
  localparam logic [2:0] REQ_ERR   = 3'd1;
  localparam logic [2:0] REQ_APPLY = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [2:0] CFG_NIN  = 3'd0;
  localparam logic [2:0] CFG_NOUT = 3'd1;
  localparam logic [2:0] CFG_RATE = 3'd2;
  localparam logic [2:0] CFG_MOM  = 3'd3;
  localparam logic [2:0] CFG_REG  = 3'd4;

  typedef struct packed {
    logic [2:0]              req_type;
    logic [3:0]              out_node;
    logic [3:0]              in_node;
    logic                    is_bias;
    logic signed [VBITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VBITS-1:0] read_value;
    logic                    saturated;
    logic                    status;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]              op;
    logic                    bad;
    logic [3:0]              out_node;
    logic [3:0]              in_node;
    logic                    is_bias;
    logic signed [VBITS-1:0] value;
  } cmd_t;

  // saturate a wide signed value into VBITS
  function automatic logic signed [VBITS-1:0] sat(input logic signed [VBITS+1:0] x,
                                                   output logic clip);
    logic signed [VBITS+1:0] hi;
    logic signed [VBITS+1:0] lo;
    hi = (VBITS+2)'(2**(VBITS-1) - 1);
    lo = -(VBITS+2)'(2**(VBITS-1));
    clip = 1'b0;
    if (x > hi) begin
      clip = 1'b1;
      sat = hi[VBITS-1:0];
    end else if (x < lo) begin
      clip = 1'b1;
      sat = lo[VBITS-1:0];
    end else begin
      sat = x[VBITS-1:0];
    end
  endfunction

  // magnitude product rounding, sign applied, saturated; p is |a|*|b|
  function automatic logic signed [VBITS-1:0] rnd(input logic [2*VBITS-1:0] p,
                                                  input logic neg, input int sh,
                                                  output logic clip);
    logic [2*VBITS:0] t;
    logic [2*VBITS:0] m;
    t = {1'b0, p} + ((2*VBITS+1)'(1) << (sh - 1));
    m = t >> sh;
    clip = 1'b0;
    if (neg) begin
      if (m > (2*VBITS+1)'(2**(VBITS-1))) begin
        clip = 1'b1;
        rnd = VBITS'(2**(VBITS-1));
      end else begin
        rnd = VBITS'(-m);
      end
    end else if (m > (2*VBITS+1)'(2**(VBITS-1) - 1)) begin
      clip = 1'b1;
      rnd = VBITS'(2**(VBITS-1) - 1);
    end else begin
      rnd = m[VBITS-1:0];
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/sgdm_front.sv
// ----------------------------------------------------------------------------
// sgdm_front
// accepts requests, range checks the indices, queues commands for the back
// ----------------------------------------------------------------------------
`default_nettype none
module sgdm_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  sgdm_pkg::req_t      req,
  input  wire [4:0]           nin,
  input  wire [4:0]           nout,
  output logic                busy,
  output logic                cmd_valid,
  output sgdm_pkg::cmd_t      cmd,
  input  wire                 cmd_take
);
  sgdm_pkg::cmd_t q [sgdm_pkg::QDEPTH];
  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  logic       push;
  logic       pop;
  sgdm_pkg::cmd_t c;
  logic bad_in;
  logic bad_out;

  // one queued item at a time: busy until the back picks it up
  logic       pending;

  assign busy = pending;
  assign push = start && !busy;
  assign pop  = cmd_take && cnt != 2'd0;
  assign cmd_valid = cnt != 2'd0;
  assign cmd = q[rp];

  always_comb begin
    bad_in  = {1'b0, req.in_node} >= nin;
    bad_out = {1'b0, req.out_node} >= nout;
    c.op = req.req_type;
    c.out_node = req.out_node;
    c.in_node = req.in_node;
    c.is_bias = req.is_bias;
    c.value = req.value;
    unique case (req.req_type)
      sgdm_pkg::REQ_ACT:   c.bad = bad_in;
      sgdm_pkg::REQ_ERR:   c.bad = bad_out;
      sgdm_pkg::REQ_APPLY: c.bad = 1'b0;
      sgdm_pkg::REQ_WRITE, sgdm_pkg::REQ_READ: c.bad = bad_out || (!req.is_bias && bad_in);
      default:             c.bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= c;
    end
    if (rst) begin
      cnt <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
      if (push) pending <= 1'b1;
      else if (pop) pending <= 1'b0;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMP(a_no_overflow, clk, rst, push, cnt != 2'd2)
  `ASSERT_IMP(a_busy_when_queued, clk, rst, cnt != 2'd0, busy)
  `ASSERT_NXT(a_push_queued, clk, rst, push, cnt != 2'd0)
endmodule
`default_nettype wire

// File: rtl/sgdm_back.sv
// ----------------------------------------------------------------------------
// sgdm_back
// sequencer that walks the stores for error, apply, write and read commands
// ----------------------------------------------------------------------------
`default_nettype none
module sgdm_back #(
  parameter int MAX_INPUTS  = sgdm_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = sgdm_pkg::MAX_OUTPUTS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cmd_valid,
  input  sgdm_pkg::cmd_t      cmd,
  output logic                cmd_take,
  input  wire [4:0]           nin,
  input  wire [4:0]           nout,
  input  wire [15:0]          rate,
  input  wire [15:0]          mom,
  input  wire [15:0]          regl,
  output logic                done,
  output sgdm_pkg::rsp_t      rsp
);
  localparam int VB = sgdm_pkg::VBITS;
  localparam int IB = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OB = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int AB = IB + OB;
  localparam int WD = 2 ** AB;

  typedef enum logic [2:0] {S_IDLE, S_CMD, S_RD, S_MUL, S_UPD, S_BIAS, S_DONE, S_CLR} st_t;
  st_t st;

  logic [VB-1:0] wmem [WD];
  logic [VB-1:0] vmem [WD];
  logic [VB-1:0] gmem [WD];
  logic signed [VB-1:0] bstore [MAX_OUTPUTS];
  logic signed [VB-1:0] bvel [MAX_OUTPUTS];
  logic signed [VB-1:0] bgrad [MAX_OUTPUTS];
  logic signed [VB-1:0] act [MAX_INPUTS];

  sgdm_pkg::cmd_t cur;
  logic [IB-1:0] ii;
  logic [OB-1:0] oo;
  logic clip;
  logic [16:0] shrink;
  logic signed [VB-1:0] wr, vr, gr;
  logic signed [VB-1:0] pv, pg, pw;
  logic                 cv, cg, cw, cu;
  logic signed [VB-1:0] nv, nw;
  logic                 c1, c2;
  logic [AB-1:0] addr;
  logic [IB-1:0] lasti;
  logic [OB-1:0] lasto;
  logic [2*VB-1:0] mv, mg, mw;
  logic ngv, ngg, ngw;

  assign addr = {oo, ii};
  assign lasti = IB'(nin - 5'd1);
  assign lasto = OB'(nout - 5'd1);
  assign cmd_take = (st == S_IDLE) && cmd_valid;

  function automatic logic [VB-1:0] absv(input logic signed [VB-1:0] x);
    absv = x[VB-1] ? VB'(-x) : x;
  endfunction

  // magnitude products, registered into pv/pg/pw, and the saturated new velocity, gradient and weight
  always_comb begin
    if (cur.op == sgdm_pkg::REQ_ERR) begin
      mv = {{VB{1'b0}}, absv(act[ii])} * {{VB{1'b0}}, absv(cur.value)};
      ngv = act[ii][VB-1] ^ cur.value[VB-1];
    end else begin
      mv = {{VB{1'b0}}, absv(vr)} * (2*VB)'(mom);
      ngv = vr[VB-1];
    end
    mg = {{VB{1'b0}}, absv(gr)} * (2*VB)'(rate);
    ngg = gr[VB-1];
    mw = {{VB{1'b0}}, absv(wr)} * (2*VB)'(shrink);
    ngw = wr[VB-1];
    c1 = 1'b0;
    c2 = 1'b0;
    if (cur.op == sgdm_pkg::REQ_ERR) begin
      nv = sgdm_pkg::sat((VB+2)'(gr) + (VB+2)'(pv), c1);
      nw = '0;
    end else begin
      nv = sgdm_pkg::sat((VB+2)'(pv) - (VB+2)'(pg), c1);
      nw = sgdm_pkg::sat((VB+2)'(wr) - (VB+2)'(pw) + (VB+2)'(nv), c2);
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      // velocity and gradient memories are cleared one entry per cycle
      st <= S_CLR;
      ii <= '0;
      oo <= '0;
      for (int k = 0; k < MAX_OUTPUTS; k++) begin
        bstore[k] <= '0;
        bvel[k] <= '0;
        bgrad[k] <= '0;
      end
    end else begin
      unique case (st)
        S_CLR: begin
          vmem[addr] <= '0;
          gmem[addr] <= '0;
          if (addr == AB'(WD - 1)) begin
            st <= S_IDLE;
          end else begin
            {oo, ii} <= addr + AB'(1);
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            clip <= 1'b0;
            rsp <= '0;
            ii <= '0;
            oo <= (cmd.op == sgdm_pkg::REQ_APPLY) ? '0 : OB'(cmd.out_node);
            shrink <= 17'(({16'd0, regl} * {16'd0, rate} + 32'd32768) >> 16);
            st <= S_CMD;
          end
        end
        S_CMD: begin
          st <= S_DONE;
          rsp.status <= cur.bad;
          if (!cur.bad) begin
            unique case (cur.op)
              sgdm_pkg::REQ_ACT: act[IB'(cur.in_node)] <= cur.value;
              sgdm_pkg::REQ_WRITE: begin
                if (cur.is_bias) bstore[OB'(cur.out_node)] <= cur.value;
                else wmem[{OB'(cur.out_node), IB'(cur.in_node)}] <= cur.value;
              end
              sgdm_pkg::REQ_READ: begin
                if (cur.is_bias) rsp.read_value <= bstore[OB'(cur.out_node)];
                else rsp.read_value <= wmem[{OB'(cur.out_node), IB'(cur.in_node)}];
              end
              sgdm_pkg::REQ_ERR, sgdm_pkg::REQ_APPLY: st <= S_RD;
              default: ;
            endcase
          end
        end
        S_RD: begin
          // registered memory reads
          wr <= wmem[addr];
          vr <= vmem[addr];
          gr <= gmem[addr];
          st <= S_MUL;
        end
        S_MUL: begin
          pv <= sgdm_pkg::rnd(mv, ngv,
                  (cur.op == sgdm_pkg::REQ_ERR) ? sgdm_pkg::FBITS : 16, cv);
          pg <= sgdm_pkg::rnd(mg, ngg, 16, cg);
          pw <= sgdm_pkg::rnd(mw, ngw, 16, cw);
          st <= S_UPD;
        end
        S_UPD: begin
          if (cur.op == sgdm_pkg::REQ_ERR) begin
            gmem[addr] <= nv;
            clip <= clip | cv | c1;
          end else begin
            vmem[addr] <= nv;
            wmem[addr] <= nw;
            gmem[addr] <= '0;
            clip <= clip | cv | cg | cw | c1 | c2;
          end
          if (ii == lasti) begin
            ii <= '0;
            st <= S_BIAS;
          end else begin
            ii <= ii + IB'(1);
            st <= S_RD;
          end
        end
        S_BIAS: begin
          if (cur.op == sgdm_pkg::REQ_ERR) begin
            bgrad[oo] <= sgdm_pkg::sat((VB+2)'(bgrad[oo]) + (VB+2)'(cur.value), cu);
            clip <= clip | cu;
            st <= S_DONE;
          end else begin
            begin : bias_apply
              logic signed [VB-1:0] a, b, v;
              logic [2*VB-1:0] p1, p2;
              logic k1, k2, k3, k4;
              p1 = {{VB{1'b0}}, absv(bvel[oo])} * (2*VB)'(mom);
              p2 = {{VB{1'b0}}, absv(bgrad[oo])} * (2*VB)'(rate);
              a = sgdm_pkg::rnd(p1, bvel[oo][VB-1], 16, k1);
              b = sgdm_pkg::rnd(p2, bgrad[oo][VB-1], 16, k2);
              v = sgdm_pkg::sat((VB+2)'(a) - (VB+2)'(b), k3);
              bvel[oo] <= v;
              bstore[oo] <= sgdm_pkg::sat((VB+2)'(bstore[oo]) + (VB+2)'(v), k4);
              bgrad[oo] <= '0;
              clip <= clip | k1 | k2 | k3 | k4;
            end
            if (oo == lasto) begin
              st <= S_DONE;
            end else begin
              oo <= oo + OB'(1);
              st <= S_RD;
            end
          end
        end
        S_DONE: begin
          rsp.saturated <= clip;
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NXT(a_done_idle, clk, rst, done, st == S_IDLE || st == S_CMD)
  `ASSERT_IMP(a_take_idle, clk, rst, cmd_take, st == S_IDLE)
  `ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
endmodule
`default_nettype wire

// File: rtl/sgd_momentum_gradient_engine.sv
// ----------------------------------------------------------------------------
// sgd_momentum_gradient_engine
// sgd with momentum and weight decay over one dense layer's stores
// ----------------------------------------------------------------------------
// The back carries out one request at a time; busy drops as soon as the back
// picks a command up, so one more request can wait in the queue behind it.
// With the back free, activation, write, read and rejected requests pass
// through the command state to done; a node error runs the read-multiply-update
// loop once per input in use, then one bias step; apply runs that loop once
// per weight and one bias step per output. After reset the back clears the
// velocity and gradient memories, one weight address per cycle, before it
// takes the first command. The result is on result for one cycle with done
// high and cannot be held off by the receiver.
`default_nettype none
module sgd_momentum_gradient_engine #(
  parameter int MAX_INPUTS  = sgdm_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = sgdm_pkg::MAX_OUTPUTS_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  output logic            busy,
  input  sgdm_pkg::req_t  req,
  output logic            done,
  output sgdm_pkg::rsp_t  result,
  input  wire             cfg_valid,
  output logic            cfg_ready,
  input  wire [2:0]       cfg_index,
  input  wire [15:0]      cfg_data
);
  logic [4:0]  nin_r, nout_r, nin, nout;
  logic [15:0] rate, mom, regl;
  logic cmd_valid, cmd_take;
  sgdm_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  // clamp counts: zero acts as one, above the maximum as the maximum
  assign nin  = (nin_r == 5'd0) ? 5'd1 :
                ({27'd0, nin_r} > MAX_INPUTS) ? 5'(MAX_INPUTS) : nin_r;
  assign nout = (nout_r == 5'd0) ? 5'd1 :
                ({27'd0, nout_r} > MAX_OUTPUTS) ? 5'(MAX_OUTPUTS) : nout_r;

  // configuration transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      nin_r <= 5'd16;
      nout_r <= 5'd16;
      rate <= 16'd655;
      mom <= 16'd58982;
      regl <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sgdm_pkg::CFG_NIN:  nin_r <= cfg_data[4:0];
        sgdm_pkg::CFG_NOUT: nout_r <= cfg_data[4:0];
        sgdm_pkg::CFG_RATE: rate <= cfg_data;
        sgdm_pkg::CFG_MOM:  mom <= cfg_data;
        sgdm_pkg::CFG_REG:  regl <= cfg_data;
        default: ;
      endcase
    end
  end

  sgdm_front u_front (
    .clk, .rst, .start, .req, .nin, .nout, .busy,
    .cmd_valid, .cmd, .cmd_take
  );

  sgdm_back #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_take, .nin, .nout,
    .rate, .mom, .regl, .done, .rsp(result)
  );
endmodule
`default_nettype wire
